// File: sv/voxel_grid_point_dedup_filter_defines.svh
// ----------------------------------------------------------------------------
// voxel_grid_point_dedup_filter_defines.svh
// Assertion macros shared by the voxel grid dedup filter RTL.
// ----------------------------------------------------------------------------
`ifndef VOXEL_GRID_POINT_DEDUP_FILTER_DEFINES_SVH
`define VOXEL_GRID_POINT_DEDUP_FILTER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define VGPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle property violated");

// Next-cycle implication, disabled in reset.
`define VGPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`endif

// File: sv/vgpd_pkg.sv
// ----------------------------------------------------------------------------
// vgpd_pkg
// Constants, codes and helpers of the voxel grid dedup filter.
// ----------------------------------------------------------------------------
package vgpd_pkg;

  // Table depth must be a power of two: the slot is the low hash bits.
  localparam int TABLE_DEPTH      = 4096;
  localparam int SLOT_W           = $clog2(TABLE_DEPTH);
  localparam int MAX_FRAME_POINTS = 1048576;
  localparam int PROBE_LIMIT      = 8;
  localparam int PROBE_W          = $clog2(PROBE_LIMIT + 1);

  localparam int COORD_W   = 21;
  localparam int KEY_W     = 3 * COORD_W;
  localparam int CNT_W     = 21;
  localparam int SUM_W     = 41;
  localparam int EPOCH_W   = 8;
  localparam int RECIP_W   = 25;
  localparam int CAP_W     = 21;
  localparam int FRAC_W    = 24;
  localparam int MUL_W     = 33;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [63:0] HC0 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HC1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HC2 = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_RECIP  = 2'd1,
    REG_CAP    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    VERDICT_KEPT = 2'd0,
    VERDICT_DUP  = 2'd1,
    VERDICT_CAP  = 2'd2,
    VERDICT_FULL = 2'd3
  } verdict_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

// File: sv/voxel_grid_point_dedup_filter.sv
// ----------------------------------------------------------------------------
// voxel_grid_point_dedup_filter
// Keeps the first point per voxel of each frame (all points with dedup off), up to a cap, and reports frame statistics.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low; its one result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot stall it. With deduplication off a point skips the key, hash and
// probe states. With it on, a point's time grows with each table probe (up to
// 8 probes) and is set by the single shared 33x33 multiplier: three key
// multiplies, then three hash mixes of two 64-bit multiplies each, every one
// built from three partial products, and by the one read port of the key
// table. The last point of a frame also runs the serial divider that forms
// the mean depth (skipped when no point survived). After reset, and after
// every 255th frame when the frame epoch wraps, a clearing pass over all 4096
// slots zeroes the slot epochs; busy stays high meanwhile and configuration
// writes are still taken.
`include "voxel_grid_point_dedup_filter_defines.svh"

module voxel_grid_point_dedup_filter
  import vgpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      frame_last,
  // result side
  output logic                      done,
  output logic [1:0]                verdict,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic signed [COORD_W-1:0] out_z,
  output logic                      frame_done,
  output logic signed [COORD_W-1:0] depth_min,
  output logic signed [COORD_W-1:0] depth_max,
  output logic signed [COORD_W-1:0] depth_mean,
  output logic [CNT_W-1:0]          points_in,
  output logic [CNT_W-1:0]          points_voxel_dropped,
  output logic [CNT_W-1:0]          points_cap_dropped,
  output logic [CNT_W-1:0]          points_out,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_KEY, ST_MIXADD, ST_MUL1, ST_MUL2,
    ST_PREAD, ST_PCHK, ST_DECIDE, ST_DIVINIT, ST_DIV, ST_EMIT
  } state_t;

  localparam logic signed [COORD_W-1:0] MEAN_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MEAN_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]   SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

  // configuration registers
  logic               voxel_enable;
  logic [RECIP_W-1:0] voxel_recip;
  logic [CAP_W-1:0]   point_cap;

  // control and datapath registers
  state_t                    state;
  logic [1:0]                step;
  logic [1:0]                kidx;
  logic [SLOT_W-1:0]         clr_addr;
  logic [SLOT_W-1:0]         slot;
  logic [PROBE_W-1:0]        probe_cnt;
  logic [EPOCH_W-1:0]        frame_epoch;
  logic signed [COORD_W-1:0] px, py, pz;
  logic                      last;
  logic [COORD_W-1:0]        kx, ky, kz;
  logic [63:0]               hash, xr, acc, mul_q;
  verdict_t                  verdict_r;
  logic [CNT_W-1:0]          count_in, count_vdrop, count_kept, count_cdrop;
  logic signed [COORD_W-1:0] run_min, run_max;
  logic signed [SUM_W-1:0]   depth_sum;
  logic [SUM_W-1:0]          div_q;
  logic [CNT_W-1:0]          rem;
  logic [DIV_CNT_W-1:0]      div_cnt;

  // key table and slot epochs
  logic [EPOCH_W-1:0] epoch_mem [TABLE_DEPTH];
  logic [KEY_W-1:0]   key_mem   [TABLE_DEPTH];
  logic [EPOCH_W-1:0] epoch_rd;
  logic [KEY_W-1:0]   key_rd;
  logic               ep_we;
  logic [SLOT_W-1:0]  ep_waddr;
  logic [EPOCH_W-1:0] ep_wdata;
  logic               key_we;

  // combinational helpers
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [63:0]               mop, mconst, acc_next, hash_next;
  logic [COORD_W-1:0]        key_sel;
  logic signed [COORD_W-1:0] coord_sel;
  logic [KEY_W-1:0]          packed_key;
  logic [31:0]               lim, kept32;
  logic                      cap_hit;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic [CNT_W:0]            rem_sh, rem_sub;
  logic                      rem_ge;
  logic signed [COORD_W-1:0] mean_val;

  assign busy       = (state != ST_IDLE);
  assign pready     = 1'b1;
  assign packed_key = {kx, ky, kz};

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_enable <= 1'b0;
      voxel_recip  <= RECIP_W'(1 << FRAC_W);
      point_cap    <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_ENABLE: voxel_enable <= pwdata[0];
        REG_RECIP:  voxel_recip  <= pwdata[RECIP_W-1:0];
        REG_CAP:    point_cap    <= pwdata[CAP_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, voxel_enable};
      REG_RECIP:  prdata = {{(DATA_W-RECIP_W){1'b0}}, voxel_recip};
      REG_CAP:    prdata = {{(DATA_W-CAP_W){1'b0}}, point_cap};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier. Key multiplies use the signed coordinate times the
  // reciprocal; the 64-bit hash multiplies are split into lo*lo, lo*hi and
  // hi*lo partial products, one per step, summed in the cycle after.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (step)
      2'd0:    coord_sel = px;
      2'd1:    coord_sel = py;
      default: coord_sel = pz;
    endcase
  end

  always_comb begin
    mop    = (state == ST_MUL1) ? (xr ^ (xr >> 30)) : (xr ^ (xr >> 27));
    mconst = (state == ST_MUL1) ? HC1 : HC2;
    if (state == ST_KEY) begin
      mul_a = MUL_W'(coord_sel);
      mul_b = {{(MUL_W-RECIP_W){1'b0}}, voxel_recip};
    end else begin
      unique case (step)
        2'd0:    begin mul_a = {1'b0, mop[31:0]};  mul_b = {1'b0, mconst[31:0]};  end
        2'd1:    begin mul_a = {1'b0, mop[31:0]};  mul_b = {1'b0, mconst[63:32]}; end
        default: begin mul_a = {1'b0, mop[63:32]}; mul_b = {1'b0, mconst[31:0]};  end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    acc_next  = (step == 2'd1) ? mul_q : acc + {mul_q[31:0], 32'h0};
    hash_next = hash ^ acc_next ^ (hash >> 31);
    unique case (kidx)
      2'd0:    key_sel = kx;
      2'd1:    key_sel = ky;
      default: key_sel = kz;
    endcase
  end

  // --------------------------------------------------------------------------
  // Filter decision, depth sum and divider
  // --------------------------------------------------------------------------
  always_comb begin
    lim = (point_cap != '0 && 32'(point_cap) < 32'(MAX_FRAME_POINTS)) ?
          32'(point_cap) : 32'(MAX_FRAME_POINTS);
    kept32  = 32'(count_kept);
    cap_hit = (kept32 >= lim);
    sum_wide = (SUM_W+1)'(depth_sum) + (SUM_W+1)'(pz);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    rem_sh  = {rem, div_q[SUM_W-1]};
    rem_ge  = (rem_sh >= {1'b0, count_kept});
    rem_sub = rem_sh - {1'b0, count_kept};
    // sign and clamp the quotient magnitude; truncation is toward zero
    if (count_kept == '0) begin
      mean_val = '0;
    end else if (!depth_sum[SUM_W-1]) begin
      mean_val = (div_q > SUM_W'(MEAN_MAX)) ? MEAN_MAX : div_q[COORD_W-1:0];
    end else begin
      mean_val = (div_q > SUM_W'(1 << (COORD_W-1))) ? MEAN_MIN :
                 (~div_q[COORD_W-1:0] + 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Table memories: one write port and one registered read port each
  // --------------------------------------------------------------------------
  always_comb begin
    ep_we    = (state == ST_CLEAR) || (state == ST_PCHK && epoch_rd != frame_epoch);
    ep_waddr = (state == ST_CLEAR) ? clr_addr : slot;
    ep_wdata = (state == ST_CLEAR) ? '0 : frame_epoch;
    key_we   = (state == ST_PCHK) && (epoch_rd != frame_epoch);
  end

  always_ff @(posedge clk) begin
    if (ep_we) begin
      epoch_mem[ep_waddr] <= ep_wdata;
    end
    epoch_rd <= epoch_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[slot] <= packed_key;
    end
    key_rd <= key_mem[slot];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      frame_epoch <= EPOCH_W'(1);
      count_in    <= '0;
      count_vdrop <= '0;
      count_kept  <= '0;
      count_cdrop <= '0;
      run_min     <= '0;
      run_max     <= '0;
      depth_sum   <= '0;
    end else begin
      // strobe done together with the result that the emit state registers
      done  <= (state == ST_EMIT);
      mul_q <= mul_p[63:0];
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(TABLE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            px        <= point_x;
            py        <= point_y;
            pz        <= point_z;
            last      <= frame_last;
            step      <= '0;
            verdict_r <= VERDICT_KEPT;
            state     <= voxel_enable ? ST_KEY : ST_DECIDE;
          end
        end
        ST_KEY: begin
          // floor(coord * recip / 2^24), wrapped to the key width
          step <= step + 1'b1;
          unique case (step)
            2'd1:    kx <= mul_q[FRAC_W +: COORD_W];
            2'd2:    ky <= mul_q[FRAC_W +: COORD_W];
            2'd3:    kz <= mul_q[FRAC_W +: COORD_W];
            default: ;
          endcase
          if (step == 2'd3) begin
            kidx  <= '0;
            hash  <= HC0;
            state <= ST_MIXADD;
          end
        end
        ST_MIXADD: begin
          xr    <= {32'h0, {(32-COORD_W){key_sel[COORD_W-1]}}, key_sel} + HC0;
          step  <= '0;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          step <= step + 1'b1;
          acc  <= acc_next;
          if (step == 2'd3) begin
            xr    <= acc_next;
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          step <= step + 1'b1;
          acc  <= acc_next;
          if (step == 2'd3) begin
            hash <= hash_next;
            if (kidx == 2'd2) begin
              slot      <= hash_next[SLOT_W-1:0];
              probe_cnt <= '0;
              state     <= ST_PREAD;
            end else begin
              kidx  <= kidx + 1'b1;
              state <= ST_MIXADD;
            end
          end
        end
        ST_PREAD: begin
          state <= ST_PCHK;
        end
        ST_PCHK: begin
          // a slot is taken only if stamped with this frame's epoch
          priority if (epoch_rd != frame_epoch) begin
            verdict_r <= VERDICT_KEPT;
            state     <= ST_DECIDE;
          end else if (key_rd == packed_key) begin
            verdict_r <= VERDICT_DUP;
            state     <= ST_DECIDE;
          end else if (probe_cnt == PROBE_W'(PROBE_LIMIT - 1)) begin
            verdict_r <= VERDICT_FULL;
            state     <= ST_DECIDE;
          end else begin
            slot      <= slot + 1'b1;
            probe_cnt <= probe_cnt + 1'b1;
            state     <= ST_PREAD;
          end
        end
        ST_DECIDE: begin
          count_in <= sat_inc(count_in);
          priority if (verdict_r == VERDICT_DUP) begin
            count_vdrop <= sat_inc(count_vdrop);
          end else if (cap_hit) begin
            verdict_r   <= VERDICT_CAP;
            count_cdrop <= sat_inc(count_cdrop);
          end else begin
            if (count_kept == '0) begin
              run_min <= pz;
              run_max <= pz;
            end else begin
              if (pz < run_min) run_min <= pz;
              if (pz > run_max) run_max <= pz;
            end
            count_kept <= sat_inc(count_kept);
            depth_sum  <= sum_sat;
          end
          state <= last ? ST_DIVINIT : ST_EMIT;
        end
        ST_DIVINIT: begin
          if (count_kept == '0) begin
            state <= ST_EMIT;
          end else begin
            div_q   <= depth_sum[SUM_W-1] ? (~depth_sum + 1'b1) : depth_sum;
            rem     <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem     <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          div_q   <= {div_q[SUM_W-2:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          verdict <= verdict_r;
          out_x   <= px;
          out_y   <= py;
          out_z   <= pz;
          if (last) begin
            frame_done           <= 1'b1;
            depth_min            <= run_min;
            depth_max            <= run_max;
            depth_mean           <= mean_val;
            points_in            <= count_in;
            points_voxel_dropped <= count_vdrop;
            points_cap_dropped   <= count_cdrop;
            points_out           <= count_kept;
            count_in    <= '0;
            count_vdrop <= '0;
            count_kept  <= '0;
            count_cdrop <= '0;
            run_min     <= '0;
            run_max     <= '0;
            depth_sum   <= '0;
            if (frame_epoch == {EPOCH_W{1'b1}}) begin
              // epoch wraps: clear every slot stamp before the next frame
              frame_epoch <= EPOCH_W'(1);
              clr_addr    <= '0;
              state       <= ST_CLEAR;
            end else begin
              frame_epoch <= frame_epoch + 1'b1;
              state       <= ST_IDLE;
            end
          end else begin
            frame_done           <= 1'b0;
            depth_min            <= '0;
            depth_max            <= '0;
            depth_mean           <= '0;
            points_in            <= '0;
            points_voxel_dropped <= '0;
            points_cap_dropped   <= '0;
            points_out           <= '0;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `VGPD_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
  `VGPD_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `VGPD_ASSERT_IMPLY(a_stats_zero_mid_frame, clk, rst, done && !frame_done, points_in == '0 && depth_mean == '0)

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel grid point dedup filter.
// ----------------------------------------------------------------------------
// Points go in through the start/busy command port. Each accepted transfer is
// run through a bit-true voxel dedup predictor, which holds its own key table,
// slot epochs and frame statistics. Its expected verdict and frame report go
// into a FIFO that the done-strobe monitor checks field by field. Registers
// are written over APB only while the filter is idle. The run covers:
// coordinate extremes, duplicates, a forced probe overflow (table full), the
// cap, several voxel sizes and an epoch wrap with its clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import vgpd_pkg::*;
;

  typedef struct {
    logic signed [COORD_W-1:0] x, y, z;
    logic                      last;
  } point_t;

  typedef struct {
    logic [1:0]                verdict;
    logic signed [COORD_W-1:0] x, y, z;
    logic                      fdone;
    logic signed [COORD_W-1:0] dmin, dmax, dmean;
    logic [CNT_W-1:0]          n_in, n_dup, n_cap, n_out;
  } point_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic                      frame_last = 1'b0;
  logic                      done;
  logic [1:0]                verdict;
  logic signed [COORD_W-1:0] out_x, out_y, out_z;
  logic                      frame_done;
  logic signed [COORD_W-1:0] depth_min, depth_max, depth_mean;
  logic [CNT_W-1:0]          points_in, points_voxel_dropped;
  logic [CNT_W-1:0]          points_cap_dropped, points_out;
  logic                      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  voxel_grid_point_dedup_filter i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the registers, key table and statistics
  // --------------------------------------------------------------------------
  bit              dedup_on;
  bit [RECIP_W-1:0] recip_q24;
  bit [CAP_W-1:0]  cap_reg;
  bit [KEY_W-1:0]  key_tab [TABLE_DEPTH];
  bit [EPOCH_W-1:0] slot_ep [TABLE_DEPTH];
  bit [EPOCH_W-1:0] cur_epoch;
  int unsigned     n_in, n_dup, n_kept, n_cap;
  longint          z_min, z_max, z_sum;

  point_t          pending_points[$];
  point_result_t   expected_results[$];
  int              err_cnt;
  int              items_sent, results_seen, frames_seen, full_seen, dup_seen, cap_seen;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Floor of coord * recip / 2^24; the arithmetic shift floors toward -inf.
  function automatic bit [COORD_W-1:0] voxel_key(input longint coord);
    longint prod;
    prod = coord * longint'(recip_q24);
    return COORD_W'(prod >>> FRAC_W);
  endfunction

  function automatic bit [63:0] mix_key(input bit [63:0] h, input bit [COORD_W-1:0] k);
    bit [63:0] v;
    v = {32'b0, {(32-COORD_W){k[COORD_W-1]}}, k};
    v = v + HC0;
    v = (v ^ (v >> 30)) * HC1;
    v = (v ^ (v >> 27)) * HC2;
    return h ^ v ^ (h >> 31);
  endfunction

  function automatic bit [SLOT_W-1:0] home_slot(input bit [COORD_W-1:0] kx, ky, kz);
    bit [63:0] h;
    h = mix_key(HC0, kx);
    h = mix_key(h, ky);
    h = mix_key(h, kz);
    return h[SLOT_W-1:0];
  endfunction

  // Probe the key table; returns kept, duplicate or table full.
  function automatic logic [1:0] probe_table(input point_t p);
    bit [COORD_W-1:0] kx, ky, kz;
    bit [KEY_W-1:0]   packed_key;
    bit [SLOT_W-1:0]  slot;
    kx = voxel_key(p.x);
    ky = voxel_key(p.y);
    kz = voxel_key(p.z);
    packed_key = {kx, ky, kz};
    slot = home_slot(kx, ky, kz);
    for (int i = 0; i < PROBE_LIMIT; i++) begin
      if (slot_ep[slot] != cur_epoch) begin
        slot_ep[slot] = cur_epoch;
        key_tab[slot] = packed_key;
        return VERDICT_KEPT;
      end
      if (key_tab[slot] == packed_key) return VERDICT_DUP;
      slot = slot + 1'b1;
    end
    return VERDICT_FULL;
  endfunction

  function automatic int unsigned sat21(input int unsigned c);
    return (c < 32'h1F_FFFF) ? c + 1 : c;
  endfunction

  function automatic point_result_t filter_point(input point_t p);
    point_result_t r;
    int unsigned   lim;
    longint        mean;
    r = '{default: '0};
    r.verdict = VERDICT_KEPT;
    n_in = sat21(n_in);
    if (dedup_on) r.verdict = probe_table(p);
    if (r.verdict == VERDICT_DUP) begin
      n_dup = sat21(n_dup);
    end else begin
      lim = (cap_reg != 0 && cap_reg < MAX_FRAME_POINTS) ? 32'(cap_reg) : MAX_FRAME_POINTS;
      if (n_kept >= lim) begin
        r.verdict = VERDICT_CAP;
        n_cap = sat21(n_cap);
      end else begin
        if (n_kept == 0) begin
          z_min = longint'(p.z);
          z_max = longint'(p.z);
        end else begin
          if (p.z < z_min) z_min = longint'(p.z);
          if (p.z > z_max) z_max = longint'(p.z);
        end
        n_kept = sat21(n_kept);
        z_sum += longint'(p.z);
        if (z_sum > 64'sh0FF_FFFF_FFFF) z_sum = 64'sh0FF_FFFF_FFFF;
        if (z_sum < -64'sh100_0000_0000) z_sum = -64'sh100_0000_0000;
      end
    end
    r.x = p.x;
    r.y = p.y;
    r.z = p.z;
    if (p.last) begin
      mean = 0;
      if (n_kept != 0) begin
        mean = z_sum / longint'(n_kept);
        if (mean > 1048575) mean = 1048575;
        if (mean < -1048576) mean = -1048576;
        r.dmin = COORD_W'(z_min);
        r.dmax = COORD_W'(z_max);
      end
      r.fdone = 1'b1;
      r.dmean = COORD_W'(mean);
      r.n_in  = CNT_W'(n_in);
      r.n_dup = CNT_W'(n_dup);
      r.n_cap = CNT_W'(n_cap);
      r.n_out = CNT_W'(n_kept);
      n_in = 0; n_dup = 0; n_kept = 0; n_cap = 0;
      z_min = 0; z_max = 0; z_sum = 0;
      cur_epoch = cur_epoch + 1'b1;
      if (cur_epoch == 0) begin
        foreach (slot_ep[i]) slot_ep[i] = '0;
        cur_epoch = 1;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: hold each point until its transfer, then wait a random gap
  // --------------------------------------------------------------------------
  logic took;
  int   gap_left;
  bit   no_gaps;

  always @(posedge clk) begin
    took <= start && !busy;
    if (!rst && start && !busy)
      expected_results.insert(expected_results.size(),
                              filter_point('{point_x, point_y, point_z, frame_last}));
  end

  always @(negedge clk) begin
    point_t p;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_points.size() > 0) begin
        p = pending_points.pop_front();
        point_x    <= p.x;
        point_y    <= p.y;
        point_z    <= p.z;
        frame_last <= p.last;
        start      <= 1'b1;
        items_sent++;
        // Flip between gapless stretches and random gaps now and then.
        if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
        gap_left = no_gaps ? 0 : $urandom_range(0, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check every done strobe against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    point_result_t e;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report("unexpected results", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (verdict !== e.verdict) report("verdict", verdict, e.verdict);
        if (out_x !== e.x) report("out_x", out_x, e.x);
        if (out_y !== e.y) report("out_y", out_y, e.y);
        if (out_z !== e.z) report("out_z", out_z, e.z);
        if (frame_done !== e.fdone) report("frame_done", frame_done, e.fdone);
        if (depth_min !== e.dmin) report("depth_min", depth_min, e.dmin);
        if (depth_max !== e.dmax) report("depth_max", depth_max, e.dmax);
        if (depth_mean !== e.dmean) report("depth_mean", depth_mean, e.dmean);
        if (points_in !== e.n_in) report("points_in", points_in, e.n_in);
        if (points_voxel_dropped !== e.n_dup)
          report("points_voxel_dropped", points_voxel_dropped, e.n_dup);
        if (points_cap_dropped !== e.n_cap)
          report("points_cap_dropped", points_cap_dropped, e.n_cap);
        if (points_out !== e.n_out) report("points_out", points_out, e.n_out);
        if (e.fdone) frames_seen++;
        if (e.verdict == VERDICT_FULL) full_seen++;
        if (e.verdict == VERDICT_DUP) dup_seen++;
        if (e.verdict == VERDICT_CAP) cap_seen++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_points.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE: dedup_on  = val[0];
      REG_RECIP:  recip_q24 = val[RECIP_W-1:0];
      default:    cap_reg   = val[CAP_W-1:0];
    endcase
  endtask

  task automatic set_mode(input bit en, input int unsigned recip, input int unsigned cap);
    wait_idle();
    apb_write(REG_ENABLE, DATA_W'(en));
    apb_write(REG_RECIP, recip);
    apb_write(REG_CAP, cap);
  endtask

  task automatic push_pt(input int x, input int y, input int z, input bit last);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    p.last = last;
    pending_points.insert(pending_points.size(), p);
  endtask

  // Mostly jittered copies of a few anchors so voxels repeat; some raw noise.
  task automatic random_frames(input int n_points);
    int anchor[4][3];
    int len, sent;
    sent = 0;
    while (sent < n_points) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
      foreach (anchor[a, c]) anchor[a][c] = $signed(COORD_W'($urandom));
      for (int i = 0; i < len; i++) begin
        int a;
        a = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
          push_pt($signed(COORD_W'($urandom)), $signed(COORD_W'($urandom)),
                  $signed(COORD_W'($urandom)), i == len - 1);
        else
          push_pt(anchor[a][0] + $urandom_range(0, 6) - 3,
                  anchor[a][1] + $urandom_range(0, 6) - 3,
                  anchor[a][2] + $urandom_range(0, 6) - 3, i == len - 1);
      end
      sent += len;
    end
  endtask

  // Find nine points that hash to the same home slot, one more than a probe
  // window holds, so the last one is kept with the table full.
  task automatic overflow_frame();
    int px[$], py[$], pz[$];
    bit [SLOT_W-1:0] target;
    int x, y, z;
    target = home_slot(COORD_W'(0), COORD_W'(0), COORD_W'(0));
    px.insert(px.size(), 0); py.insert(py.size(), 0); pz.insert(pz.size(), 0);
    while (px.size() < PROBE_LIMIT + 1) begin
      x = $urandom_range(1, 60000);
      y = $urandom_range(0, 60000) - 30000;
      z = $urandom_range(0, 60000) - 30000;
      if (home_slot(COORD_W'(x), COORD_W'(y), COORD_W'(z)) == target) begin
        px.insert(px.size(), x); py.insert(py.size(), y); pz.insert(pz.size(), z);
      end
    end
    foreach (px[i]) push_pt(px[i], py[i], pz[i], 1'b0);
    push_pt(px[PROBE_LIMIT], py[PROBE_LIMIT], pz[PROBE_LIMIT], 1'b0);
    push_pt(0, 0, 0, 1'b1);
  endtask

  initial begin
    dedup_on  = 1'b0;
    recip_q24 = 25'd16777216;
    cap_reg   = '0;
    cur_epoch = 1;
    no_gaps   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Dedup off after reset: coordinate extremes, each bit both ways.
    push_pt(-1048576, 1048575, -1048576, 1'b0);
    push_pt(1048575, -1048576, 1048575, 1'b0);
    push_pt(0, -1, 0, 1'b0);
    push_pt(-1, 0, -1, 1'b1);
    push_pt(-1048576, -1048576, -1048576, 1'b1);
    push_pt(5, 5, 1048575, 1'b1);

    // 1 mm voxels: repeats, probe overflow, a point after it stays kept.
    set_mode(1'b1, 16777216, 0);
    push_pt(7, -7, 100, 1'b0);
    push_pt(7, -7, 100, 1'b0);
    push_pt(-1048576, 1048575, -3, 1'b0);
    push_pt(-1048576, 1048575, -3, 1'b1);
    overflow_frame();

    // Caps of one and of two; coarsest voxel maps all to 0 or -1.
    set_mode(1'b1, 1, 1);
    push_pt(100, 200, -50, 1'b0);
    push_pt(-100, 200, -60, 1'b0);
    push_pt(-100, 300, -70, 1'b0);
    push_pt(100, 250, 9, 1'b1);
    set_mode(1'b0, 16777216, 2);
    push_pt(1, 2, 3, 1'b0);
    push_pt(4, 5, 6, 1'b0);
    push_pt(7, 8, 9, 1'b1);

    // Random phases over a spread of settings, extremes included.
    set_mode(1'b1, 16777216 / 8, 1048576);
    random_frames(50);
    set_mode(1'b1, 16777216 / 2, 0);
    random_frames(50);
    set_mode(1'b1, $urandom_range(1, 16777216), $urandom_range(1, 12));
    random_frames(50);
    set_mode(1'b0, $urandom_range(1, 16777216), $urandom_range(0, 6));
    random_frames(40);
    set_mode(1'b1, 16777216, 0);
    random_frames(50);

    // Run the frame epoch round its wrap, then check repeats still resolve.
    set_mode(1'b1, 16777216 / 4, 0);
    for (int i = 0; i < 260; i++) push_pt(i, -i, i - 130, 1'b1);
    push_pt(3, 3, 3, 1'b0);
    push_pt(3, 3, 3, 1'b1);

    wait_idle();
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0) begin
      report("results never arrived", 0, expected_results.size());
    end
    $display("Sent %0d points in %0d frames; %0d results checked.",
             items_sent, frames_seen, results_seen);
    $display("Verdicts seen: %0d duplicate, %0d capped, %0d table full; %0d mismatches.",
             dup_seen, cap_seen, full_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run, clearing passes included.
  initial begin
    #(8 * 2000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
